[hdl/bbc_pkg.sv]
// shared types, character codes and bracket decoders for the bracket checker
package bbc_pkg;

	typedef enum logic [1:0] {
		KIND_ROUND  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stack_ctl_t;

	localparam logic [7:0] CHAR_NUL         = 8'h00;
	localparam logic [7:0] CHAR_OPEN_ROUND  = 8'h28;
	localparam logic [7:0] CHAR_CLOSE_ROUND = 8'h29;
	localparam logic [7:0] CHAR_OPEN_SQUARE = 8'h5B;
	localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
	localparam logic [7:0] CHAR_OPEN_CURLY  = 8'h7B;
	localparam logic [7:0] CHAR_CLOSE_CURLY = 8'h7D;

	function automatic kind_t open_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CHAR_OPEN_ROUND:  k = KIND_ROUND;
			CHAR_OPEN_SQUARE: k = KIND_SQUARE;
			CHAR_OPEN_CURLY:  k = KIND_CURLY;
			default:          k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic kind_t close_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CHAR_CLOSE_ROUND:  k = KIND_ROUND;
			CHAR_CLOSE_SQUARE: k = KIND_SQUARE;
			CHAR_CLOSE_CURLY:  k = KIND_CURLY;
			default:           k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage

[hdl/bbc_cell.sv]
// one stack entry cell: shifts down on push, up on pop
module bbc_cell
	import bbc_pkg::*;
(
	input  logic       clk,
	input  stack_ctl_t ctl,
	input  kind_t      upper_kind,
	input  kind_t      lower_kind,
	output kind_t      kind
);

	kind_t kind_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			kind_q <= upper_kind;
		end else if (ctl.pop) begin
			kind_q <= lower_kind;
		end
	end

	assign kind = kind_q;

endmodule

[hdl/bbc_cell_row.sv]
// row of stack cells, top of stack in cell 0
module bbc_cell_row
	import bbc_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic       clk,
	input  stack_ctl_t ctl,
	input  kind_t      push_kind,
	output kind_t      top_kind
);

	kind_t kinds [STACK_DEPTH];

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		kind_t upper;
		kind_t lower;
		if (i == 0) begin : g_first
			assign upper = push_kind;
		end else begin : g_mid_up
			assign upper = kinds[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign lower = kinds[i];
		end else begin : g_mid_dn
			assign lower = kinds[i+1];
		end
		bbc_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.upper_kind (upper),
			.lower_kind (lower),
			.kind       (kinds[i])
		);
	end

	assign top_kind = kinds[0];

endmodule

[hdl/bracket_balance_checker_unit.sv]
// top level of the bracket balance checker
//
// input channel: in_valid / in_ready with char_code, one byte per transaction.
// a byte of 0 ends the string; bracket bytes update the bracket stack until a failure, other bytes are ignored.
// output channel: out_valid / out_ready with matched and overflowed, one
// transaction per terminator, none for other bytes.
// throughput: one byte per cycle while in_ready is high. each push or pop shifts the whole cell row
// in the cycle the byte is taken, so the next byte sees the new top at once.
// the result appears on the output in the cycle after the terminator
// is taken, from the output register.
// a held result stalls input only while out_ready is low; then in_ready drops.
// reset clears the depth count, the failure and overflow flags and the output
// valid; stack cell contents are not cleared and are never read before push.
module bracket_balance_checker_unit
	import bbc_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       matched,
	output logic       overflowed
);

	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [CW-1:0] count_q;
	logic          failed_q;
	logic          overflow_q;
	logic          out_valid_q;
	logic          matched_q;
	logic          overflowed_q;

	logic       accept;
	logic       is_term;
	logic       live;
	kind_t      okind;
	kind_t      ckind;
	kind_t      top_kind;
	logic       is_open;
	logic       is_close;
	logic       full;
	logic       empty;
	stack_ctl_t ctl;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_term  = (char_code == CHAR_NUL);
	assign live     = accept && !is_term && !failed_q;
	assign okind    = open_kind(char_code);
	assign ckind    = close_kind(char_code);
	assign is_open  = live && (okind != KIND_NONE);
	assign is_close = live && (ckind != KIND_NONE);
	assign full     = (count_q == CW'(STACK_DEPTH));
	assign empty    = (count_q == '0);
	assign ctl.push = is_open && !full;
	assign ctl.pop  = is_close && !empty;

	bbc_cell_row #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_row (
		.clk       (clk),
		.ctl       (ctl),
		.push_kind (okind),
		.top_kind  (top_kind)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			failed_q    <= 1'b0;
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && is_term) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				failed_q    <= 1'b0;
				overflow_q  <= 1'b0;
			end else begin
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
				if (ctl.push) begin
					count_q <= count_q + CW'(1);
				end
				if (ctl.pop) begin
					count_q <= count_q - CW'(1);
				end
				if (is_open && full) begin
					failed_q   <= 1'b1;
					overflow_q <= 1'b1;
				end
				if (is_close && (empty || (top_kind != ckind))) begin
					failed_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_term) begin
			matched_q    <= empty && !failed_q;
			overflowed_q <= overflow_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign matched    = matched_q;
	assign overflowed = overflowed_q;

endmodule

[tb/tb.sv]
// testbench for the bracket balance checker: predicted verdicts per string, random handshakes
`timescale 1ns / 1ps

module tb;
	import bbc_pkg::*;

	localparam int STACK_DEPTH = 64;
	localparam int TARGET_ITEMS = 1850;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 250;
	localparam int QUIET_FROM = 1000;
	localparam int QUIET_TO = 1300;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic matched;
		logic overflowed;
	} verdict_t;

	class balance_scoreboard;
		kind_t    kinds[STACK_DEPTH];
		int       depth;
		bit       failed;
		bit       overflow;
		verdict_t verdicts[$];
		int       errors;

		function new();
			depth = 0;
			failed = 1'b0;
			overflow = 1'b0;
			errors = 0;
		endfunction

		function void note_char(logic [7:0] c);
			verdict_t v;
			kind_t    k;
			bit       is_open;
			bit       is_close;
			if (c == CHAR_NUL) begin
				v.matched = (depth == 0) && !failed;
				v.overflowed = overflow;
				verdicts.push_back(v);
				depth = 0;
				failed = 1'b0;
				overflow = 1'b0;
				return;
			end
			if (failed)
				return;
			is_open = 1'b0;
			is_close = 1'b0;
			k = KIND_NONE;
			case (c)
				CHAR_OPEN_ROUND: begin
					is_open = 1'b1;
					k = KIND_ROUND;
				end
				CHAR_OPEN_SQUARE: begin
					is_open = 1'b1;
					k = KIND_SQUARE;
				end
				CHAR_OPEN_CURLY: begin
					is_open = 1'b1;
					k = KIND_CURLY;
				end
				CHAR_CLOSE_ROUND: begin
					is_close = 1'b1;
					k = KIND_ROUND;
				end
				CHAR_CLOSE_SQUARE: begin
					is_close = 1'b1;
					k = KIND_SQUARE;
				end
				CHAR_CLOSE_CURLY: begin
					is_close = 1'b1;
					k = KIND_CURLY;
				end
				default: ;
			endcase
			if (is_open) begin
				if (depth >= STACK_DEPTH) begin
					failed = 1'b1;
					overflow = 1'b1;
				end else begin
					kinds[depth] = k;
					depth++;
				end
			end else if (is_close) begin
				if (depth == 0) begin
					failed = 1'b1;
				end else begin
					depth--;
					if (kinds[depth] != k)
						failed = 1'b1;
				end
			end
		endfunction

		function void check_result(logic m, logic o);
			verdict_t want;
			if (verdicts.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: matched=%0b overflowed=%0b", m, o);
				return;
			end
			want = verdicts.pop_front();
			if (m !== want.matched || o !== want.overflowed) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected matched=%0b overflowed=%0b, got matched=%0b overflowed=%0b",
						want.matched, want.overflowed, m, o);
			end
		endfunction

		function int pending();
			return verdicts.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_code = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       matched;
	logic       overflowed;

	balance_scoreboard sb = new();
	int sent_count = 0;
	bit no_idle = 1'b0;
	int cycles = 0;

	bracket_balance_checker_unit #(
		.STACK_DEPTH(STACK_DEPTH)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.matched    (matched),
		.overflowed (overflowed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(matched, overflowed);
	end

	initial begin : receiver
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && sent_count >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_idle || ($urandom_range(0, 99) >= 17);
			end
		end
	end

	function automatic logic [7:0] open_char(kind_t k);
		case (k)
			KIND_ROUND:  return CHAR_OPEN_ROUND;
			KIND_SQUARE: return CHAR_OPEN_SQUARE;
			default:     return CHAR_OPEN_CURLY;
		endcase
	endfunction

	function automatic logic [7:0] close_char(kind_t k);
		case (k)
			KIND_ROUND:  return CHAR_CLOSE_ROUND;
			KIND_SQUARE: return CHAR_CLOSE_SQUARE;
			default:     return CHAR_CLOSE_CURLY;
		endcase
	endfunction

	task automatic send_char(input logic [7:0] c);
		if (!no_idle && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while (!no_idle && $urandom_range(0, 99) < 17);
		end
		in_valid <= 1'b1;
		char_code <= c;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_char(c);
		sent_count++;
		no_idle = (sent_count >= QUIET_FROM) && (sent_count < QUIET_TO);
	endtask

	task automatic send_nested(input bit broken, input int max_len);
		kind_t stk[$];
		kind_t k;
		int    len;
		int    bad_at;
		int    r;
		bit    leave_open;
		len = $urandom_range(0, max_len);
		bad_at = broken ? $urandom_range(0, len) : -1;
		leave_open = 1'b0;
		for (int i = 0; i <= len; i++) begin
			if (i == bad_at) begin
				r = $urandom_range(0, 2);
				if (stk.size() > 0 && r == 0) begin
					k = stk.pop_back();
					send_char(close_char(kind_t'((int'(k) + $urandom_range(1, 2)) % 3)));
				end else if (stk.size() > 0 && r == 1) begin
					leave_open = 1'b1;
				end else begin
					send_char(close_char(kind_t'($urandom_range(0, 2))));
				end
			end
			if (i == len)
				break;
			r = $urandom_range(0, 99);
			if (r < 40 && stk.size() < STACK_DEPTH) begin
				k = kind_t'($urandom_range(0, 2));
				stk.push_back(k);
				send_char(open_char(k));
			end else if (r < 80 && stk.size() > 0) begin
				send_char(close_char(stk.pop_back()));
			end else begin
				send_char(8'($urandom_range(1, 255)));
			end
		end
		while (stk.size() > 0 && !leave_open)
			send_char(close_char(stk.pop_back()));
		send_char(CHAR_NUL);
	endtask

	task automatic send_deep();
		kind_t stk[$];
		kind_t k;
		int    n;
		n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3);
		for (int i = 0; i < n; i++) begin
			k = kind_t'($urandom_range(0, 2));
			if (stk.size() < STACK_DEPTH)
				stk.push_back(k);
			send_char(open_char(k));
		end
		if (n <= STACK_DEPTH) begin
			while (stk.size() > 0)
				send_char(close_char(stk.pop_back()));
		end else if ($urandom_range(0, 1) == 1) begin
			send_char(close_char(stk.pop_back()));
		end
		send_char(CHAR_NUL);
	endtask

	task automatic send_noise();
		int len;
		len = $urandom_range(0, 10);
		for (int i = 0; i < len; i++)
			send_char(8'($urandom_range(1, 255)));
		send_char(CHAR_NUL);
	endtask

	logic [7:0] directed[23] = '{
		CHAR_NUL,
		CHAR_OPEN_ROUND, CHAR_OPEN_SQUARE, CHAR_OPEN_CURLY,
		CHAR_CLOSE_CURLY, CHAR_CLOSE_SQUARE, CHAR_CLOSE_ROUND, CHAR_NUL,
		CHAR_CLOSE_ROUND, CHAR_NUL,
		CHAR_OPEN_ROUND, CHAR_CLOSE_SQUARE, CHAR_OPEN_ROUND, CHAR_CLOSE_ROUND, CHAR_NUL,
		CHAR_OPEN_CURLY, CHAR_OPEN_SQUARE, CHAR_OPEN_ROUND, CHAR_NUL,
		8'hFF, 8'h01, 8'h80, CHAR_NUL
	};

	initial begin : stimulus
		int r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[i])
			send_char(directed[i]);
		while (sent_count < TARGET_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				send_nested(1'b0, 16);
			else if (r < 70)
				send_nested(1'b1, 16);
			else if (r < 88)
				send_noise();
			else if (r < 97)
				send_nested($urandom_range(0, 1), 60);
			else
				send_deep();
		end
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
hdl/bbc_pkg.sv
hdl/bbc_cell.sv
hdl/bbc_cell_row.sv
hdl/bracket_balance_checker_unit.sv
tb/tb.sv
